[hdl/slm_pkg.sv]
// ----------------------------------------------------------------------------
// slm_pkg: shared types and codes of the sorted list merge core.
// Holds the item opcodes, fixed field widths and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slm_pkg;

  // Fixed field widths of the item interfaces.
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int OP_W   = 2;

  // Item opcodes.
  localparam logic [OP_W-1:0] OP_PUSH_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN         = 2'd2;

  // Sequencer states: idle takes pushes and runs, merge walks both stores.
  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

endpackage

[hdl/sorted_list_merge_core.sv]
// ----------------------------------------------------------------------------
// sorted_list_merge_core: merge of two ascending lists held in block memories.
// A run's first item passes the memory read register (read starts in the accept cycle),
// then the output register; then one per unstalled cycle. Input stalls until the last
// item is registered. Reset clears state and counts, not the memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_merge_core #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input item channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [slm_pkg::OP_W-1:0]         opcode,
  input  logic signed [slm_pkg::DATA_W-1:0] value,
  // Result item channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [slm_pkg::DATA_W-1:0] merged_value,
  output logic [slm_pkg::POS_W-1:0]        position,
  output logic                             from_second,
  output logic                             last,
  output logic                             dropped
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int TOT_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

  // List memories, one synchronous read port each.
  logic [slm_pkg::DATA_W-1:0] first_mem  [LIST_DEPTH];
  logic [slm_pkg::DATA_W-1:0] second_mem [LIST_DEPTH];
  logic [slm_pkg::DATA_W-1:0] first_rdata;
  logic [slm_pkg::DATA_W-1:0] second_rdata;
  logic [IDX_W-1:0]           first_raddr;
  logic [IDX_W-1:0]           second_raddr;

  slm_pkg::state_t state, state_next;

  logic [CNT_W-1:0] first_count;
  logic [CNT_W-1:0] second_count;
  logic             drop_seen;
  logic [CNT_W-1:0] rd_first, rd_first_next;
  logic [CNT_W-1:0] rd_second, rd_second_next;
  logic [TOT_W-1:0] out_index;
  logic [TOT_W-1:0] total;

  logic in_accept;
  logic push_first;
  logic push_second;
  logic run_go;
  logic run_empty;
  logic out_free;
  logic emit;
  logic take_first;
  logic emit_last;

  // Input decode; items are taken only while idle.
  assign in_accept = in_valid && !in_stall;
  always_comb begin
    push_first  = 1'b0;
    push_second = 1'b0;
    run_go      = 1'b0;
    unique case (opcode)
      slm_pkg::OP_PUSH_FIRST:  push_first  = in_accept;
      slm_pkg::OP_PUSH_SECOND: push_second = in_accept;
      slm_pkg::OP_RUN:         run_go      = in_accept;
      default: ;
    endcase
  end

  assign total     = TOT_W'(first_count) + TOT_W'(second_count);
  assign run_empty = (total == '0);

  // Merge choice on the two heads read out of memory.
  assign out_free   = !out_valid || !out_stall;
  assign take_first = (rd_first < first_count) &&
                      ((rd_second >= second_count) ||
                       ($signed(first_rdata) <= $signed(second_rdata)));
  assign emit       = (state == slm_pkg::ST_MERGE) && out_free;
  assign emit_last  = emit && ((out_index + TOT_W'(1)) == total);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        if (run_go && !run_empty) state_next = slm_pkg::ST_MERGE;
      end
      slm_pkg::ST_MERGE: begin
        if (emit_last) state_next = slm_pkg::ST_IDLE;
      end
      default: state_next = slm_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    unique case (state)
      slm_pkg::ST_IDLE:  in_stall = 1'b0;
      slm_pkg::ST_MERGE: in_stall = 1'b1;
      default:           in_stall = 1'b1;
    endcase
  end

  // Read pointers; the memory address follows the next pointer value so
  // that the read data always holds the current head of each list.
  always_comb begin
    rd_first_next  = rd_first;
    rd_second_next = rd_second;
    if (run_go) begin
      rd_first_next  = '0;
      rd_second_next = '0;
    end else if (emit) begin
      if (take_first) rd_first_next  = rd_first + CNT_W'(1);
      else            rd_second_next = rd_second + CNT_W'(1);
    end
  end

  assign first_raddr  = (rd_first_next < DEPTH_CNT) ? rd_first_next[IDX_W-1:0] : '0;
  assign second_raddr = (rd_second_next < DEPTH_CNT) ? rd_second_next[IDX_W-1:0] : '0;

  // First list memory.
  always_ff @(posedge clk) begin
    if (push_first && (first_count < DEPTH_CNT)) begin
      first_mem[first_count[IDX_W-1:0]] <= value;
    end
    first_rdata <= first_mem[first_raddr];
  end

  // Second list memory.
  always_ff @(posedge clk) begin
    if (push_second && (second_count < DEPTH_CNT)) begin
      second_mem[second_count[IDX_W-1:0]] <= value;
    end
    second_rdata <= second_mem[second_raddr];
  end

  // Control registers: state, counts, drop flag, pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= slm_pkg::ST_IDLE;
      first_count  <= '0;
      second_count <= '0;
      drop_seen    <= 1'b0;
      rd_first     <= '0;
      rd_second    <= '0;
      out_index    <= '0;
    end else begin
      state     <= state_next;
      rd_first  <= rd_first_next;
      rd_second <= rd_second_next;
      if (push_first) begin
        if (first_count < DEPTH_CNT) first_count <= first_count + CNT_W'(1);
        else                         drop_seen   <= 1'b1;
      end
      if (push_second) begin
        if (second_count < DEPTH_CNT) second_count <= second_count + CNT_W'(1);
        else                          drop_seen    <= 1'b1;
      end
      if (run_go) begin
        out_index <= '0;
      end else if (emit) begin
        out_index <= out_index + TOT_W'(1);
      end
      // A run ends by emptying both lists and clearing the drop flag.
      if ((run_go && run_empty) || emit_last) begin
        first_count  <= '0;
        second_count <= '0;
        drop_seen    <= 1'b0;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      merged_value <= take_first ? first_rdata : second_rdata;
      position     <= slm_pkg::POS_W'(out_index);
      from_second  <= !take_first;
      last         <= (out_index + TOT_W'(1)) == total;
      dropped      <= drop_seen;
    end
  end

`ifndef NO_ASSERTIONS
  // Every emitted item advances exactly one pointer.
  a_index_sum: assert property (@(posedge clk) disable iff (rst)
    (state == slm_pkg::ST_MERGE) |->
      (out_index == (TOT_W'(rd_first) + TOT_W'(rd_second))))
    else $error("merge index does not match the pointer sum");

  // Pointers never run past their list during a merge.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == slm_pkg::ST_MERGE) |->
      ((rd_first <= first_count) && (rd_second <= second_count)))
    else $error("merge pointer beyond list count");

  // The final item of a run leaves both lists empty and the block idle.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    emit_last |=> ((state == slm_pkg::ST_IDLE) && (first_count == '0) &&
                   (second_count == '0) && !drop_seen && out_valid && last))
    else $error("run did not end cleanly");
`endif

endmodule

[dv/tb_sorted_list_merge_core.sv]
// ----------------------------------------------------------------------------
// tb_sorted_list_merge_core: self-checking bench for the sorted list merge core.
// Pushes values into both lists and issues merge runs. A built-in merge
// predictor checks every result field, under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_list_merge_core;

  localparam int LIST_DEPTH   = 32;
  localparam int QUIET_LIMIT  = 3000;
  localparam int END_CYCLES   = 16;
  localparam int MAX_REPORTS  = 10;
  localparam logic [slm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Entries of the stimulus queue: items and in-line sequencing controls.
  typedef enum int {
    STIM_ITEM,
    STIM_DRAIN,
    STIM_IDLE_MIX,
    STIM_RECV_HOLD
  } stim_kind_t;

  typedef enum int {
    SHAPE_ASCEND,
    SHAPE_TIES,
    SHAPE_SCRAMBLED
  } list_shape_t;

  typedef struct {
    stim_kind_t                        kind;
    logic [slm_pkg::OP_W-1:0]          op;
    logic signed [slm_pkg::DATA_W-1:0] val;
    int                                send_pct;
    int                                recv_pct;
    int                                hold;
  } stim_t;

  typedef struct {
    logic signed [slm_pkg::DATA_W-1:0] merged_value;
    logic [slm_pkg::POS_W-1:0]         position;
    logic                              from_second;
    logic                              last;
    logic                              dropped;
  } merge_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [slm_pkg::OP_W-1:0]          opcode = '0;
  logic signed [slm_pkg::DATA_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [slm_pkg::DATA_W-1:0] merged_value;
  logic [slm_pkg::POS_W-1:0]         position;
  logic                              from_second;
  logic                              last;
  logic                              dropped;

  stim_t         pending[$];
  merge_result_t merge_expected[$];

  // Predictor copy of the two lists and the sticky drop flag.
  logic signed [slm_pkg::DATA_W-1:0] first_list[LIST_DEPTH];
  logic signed [slm_pkg::DATA_W-1:0] second_list[LIST_DEPTH];
  int                                first_len = 0;
  int                                second_len = 0;
  logic                              drop_pending = 1'b0;

  logic in_taken = 1'b0;
  logic stim_done = 1'b0;
  int   send_pct = 0;
  int   recv_pct = 0;
  int   hold_asked = 0;
  int   hold_seen = 0;
  int   hold_cycles = 0;
  int   hold_left = 0;
  int   stim_items = 0;
  int   errors = 0;

  sorted_list_merge_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .merged_value(merged_value),
    .position(position),
    .from_second(from_second),
    .last(last),
    .dropped(dropped)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Update the predicted lists for one accepted item; a run emits the merge.
  task automatic predict_merge(logic [slm_pkg::OP_W-1:0] op,
                               logic signed [slm_pkg::DATA_W-1:0] val);
    merge_result_t r;
    int            i;
    int            j;
    int            total;
    logic          take_first;
    i = 0;
    j = 0;
    case (op)
      slm_pkg::OP_PUSH_FIRST: begin
        if (first_len < LIST_DEPTH) begin
          first_list[first_len] = val;
          first_len++;
        end else begin
          drop_pending = 1'b1;
        end
      end
      slm_pkg::OP_PUSH_SECOND: begin
        if (second_len < LIST_DEPTH) begin
          second_list[second_len] = val;
          second_len++;
        end else begin
          drop_pending = 1'b1;
        end
      end
      slm_pkg::OP_RUN: begin
        total = first_len + second_len;
        for (int k = 0; k < total; k++) begin
          // The first list wins ties; an exhausted list yields to the other.
          take_first = (i < first_len) &&
                       (j >= second_len || first_list[i] <= second_list[j]);
          if (take_first) begin
            r.merged_value = first_list[i];
            r.from_second  = 1'b0;
            i++;
          end else begin
            r.merged_value = second_list[j];
            r.from_second  = 1'b1;
            j++;
          end
          r.position = slm_pkg::POS_W'(k);
          r.last     = (k == total - 1);
          r.dropped  = drop_pending;
          merge_expected.push_back(r);
        end
        first_len    = 0;
        second_len   = 0;
        drop_pending = 1'b0;
      end
      default: begin
        // Unused opcodes leave the state alone.
      end
    endcase
  endtask

  // Sample both channels at the rising edge, check results, then predict.
  always @(posedge clk) begin : check_proc
    merge_result_t exp_r;
    in_taken = !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (merge_expected.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result value %0d pos %0d", $time, merged_value,
                   position);
      end else begin
        exp_r = merge_expected.pop_front();
        if (merged_value !== exp_r.merged_value || position !== exp_r.position ||
            from_second !== exp_r.from_second || last !== exp_r.last ||
            dropped !== exp_r.dropped) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: expected value %0d pos %0d second %0b last %0b dropped %0b",
                     $time, exp_r.merged_value, exp_r.position, exp_r.from_second,
                     exp_r.last, exp_r.dropped);
            $display("%0t: actual   value %0d pos %0d second %0b last %0b dropped %0b",
                     $time, merged_value, position, from_second, last, dropped);
          end
        end
      end
    end
    if (in_taken)
      predict_merge(opcode, value);
  end

  // Input driver: handles controls at the queue head, then offers the next item.
  always @(negedge clk) begin : drive_proc
    stim_t cur;
    logic  go;
    go = 1'b1;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      while (go && pending.size() != 0 && pending[0].kind != STIM_ITEM) begin
        case (pending[0].kind)
          STIM_DRAIN: begin
            if (merge_expected.size() == 0)
              void'(pending.pop_front());
            else
              go = 1'b0;
          end
          STIM_IDLE_MIX: begin
            send_pct = pending[0].send_pct;
            recv_pct <= pending[0].recv_pct;
            void'(pending.pop_front());
          end
          default: begin
            hold_cycles <= pending[0].hold;
            hold_asked  <= hold_asked + 1;
            void'(pending.pop_front());
          end
        endcase
      end
      if (go && pending.size() != 0 && $urandom_range(99) >= send_pct) begin
        cur = pending.pop_front();
        opcode   <= cur.op;
        value    <= cur.val;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      if (go && pending.size() == 0)
        stim_done <= 1'b1;
    end
  end

  // Result receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin : recv_proc
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= hold_cycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Watchdog: ends the run after a long stretch with no handshake on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic add_entry(stim_kind_t kind, logic [slm_pkg::OP_W-1:0] op,
                           logic signed [slm_pkg::DATA_W-1:0] val, int a, int b);
    stim_t s;
    s.kind     = kind;
    s.op       = op;
    s.val      = val;
    s.send_pct = a;
    s.recv_pct = b;
    s.hold     = a;
    pending.push_back(s);
  endtask

  task automatic add_item(logic [slm_pkg::OP_W-1:0] op,
                          logic signed [slm_pkg::DATA_W-1:0] val);
    add_entry(STIM_ITEM, op, val, 0, 0);
    if (op != OP_UNUSED)
      stim_items++;
  endtask

  // Queue two lists of the given lengths with interleaved pushes, then a run.
  task automatic add_list_pair(int n1, int n2, list_shape_t shape);
    logic signed [slm_pkg::DATA_W-1:0] a_q[$];
    logic signed [slm_pkg::DATA_W-1:0] b_q[$];
    longint                            cur;
    int                                n;
    int                                s;
    for (s = 0; s < 2; s++) begin
      n = (s == 0) ? n1 : n2;
      if (shape == SHAPE_TIES)
        cur = longint'($urandom_range(6)) - 3;
      else
        cur = $signed($urandom());
      for (int e = 0; e < n; e++) begin
        if (shape == SHAPE_SCRAMBLED)
          cur = $signed($urandom());
        else if (e != 0)
          cur = cur + ((shape == SHAPE_TIES) ? $urandom_range(2) :
                       $urandom_range(32'h0400_0000));
        // Saturate at the top so the list stays ascending.
        if (cur > 64'sd2147483647)
          cur = 64'sd2147483647;
        if (s == 0)
          a_q.push_back(cur[slm_pkg::DATA_W-1:0]);
        else
          b_q.push_back(cur[slm_pkg::DATA_W-1:0]);
      end
    end
    while (a_q.size() != 0 || b_q.size() != 0) begin
      if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(1) == 1))
        add_item(slm_pkg::OP_PUSH_FIRST, a_q.pop_front());
      else
        add_item(slm_pkg::OP_PUSH_SECOND, b_q.pop_front());
    end
    add_item(slm_pkg::OP_RUN, $signed($urandom()));
  endtask

  // One random group: mostly short well-formed lists, some full, some broken.
  task automatic add_random_group();
    int          kind;
    int          n1;
    int          n2;
    list_shape_t shape;
    kind = $urandom_range(99);
    if ($urandom_range(19) == 0)
      add_item(OP_UNUSED, $signed($urandom()));
    if (kind < 3) begin
      n1 = $urandom_range(LIST_DEPTH, LIST_DEPTH + 2);
      n2 = $urandom_range(LIST_DEPTH, LIST_DEPTH + 2);
    end else if (kind < 8) begin
      n1 = $urandom_range(LIST_DEPTH, LIST_DEPTH + 3);
      n2 = $urandom_range(4);
      if ($urandom_range(1) == 1) begin
        n2 = n1;
        n1 = $urandom_range(4);
      end
    end else if (kind < 14) begin
      n1 = 0;
      n2 = 0;
    end else begin
      n1 = $urandom_range(6);
      n2 = $urandom_range(6);
    end
    kind = $urandom_range(9);
    if (kind < 7)
      shape = SHAPE_ASCEND;
    else if (kind < 9)
      shape = SHAPE_TIES;
    else
      shape = SHAPE_SCRAMBLED;
    add_list_pair(n1, n2, shape);
  endtask

  // Build the whole stimulus, release reset and wait for the last result.
  initial begin : main
    int target;
    target = 0;

    // Directed part: empty run, ignored opcode, extremes, ties, odd orders.
    add_entry(STIM_IDLE_MIX, slm_pkg::OP_PUSH_FIRST, '0, 0, 0);
    add_item(slm_pkg::OP_RUN, '0);
    add_item(OP_UNUSED, 32'shFFFF_FFFF);
    add_item(slm_pkg::OP_PUSH_FIRST, 32'sh8000_0000);
    add_item(slm_pkg::OP_PUSH_SECOND, 32'sh8000_0000);
    add_item(slm_pkg::OP_PUSH_SECOND, 32'sh0000_0000);
    add_item(slm_pkg::OP_PUSH_FIRST, 32'sh7FFF_FFFF);
    add_item(slm_pkg::OP_PUSH_SECOND, 32'sh7FFF_FFFF);
    add_item(slm_pkg::OP_RUN, 32'sh7FFF_FFFF);
    add_item(slm_pkg::OP_PUSH_SECOND, 32'sd7);
    add_item(slm_pkg::OP_PUSH_SECOND, -32'sd1);
    add_item(slm_pkg::OP_PUSH_FIRST, 32'sd2);
    add_item(slm_pkg::OP_PUSH_SECOND, 32'sd4);
    add_item(slm_pkg::OP_RUN, 32'sh8000_0000);
    add_item(slm_pkg::OP_PUSH_FIRST, 32'sd10);
    add_item(slm_pkg::OP_PUSH_FIRST, 32'sd10);
    add_item(slm_pkg::OP_PUSH_FIRST, 32'shAAAA_AAAA);
    add_item(slm_pkg::OP_RUN, '0);
    add_item(slm_pkg::OP_PUSH_SECOND, 32'sh5555_5555);
    add_item(slm_pkg::OP_RUN, '0);
    add_entry(STIM_DRAIN, slm_pkg::OP_PUSH_FIRST, '0, 0, 0);

    // Back-pressure: the receiver holds off while a full list and more arrive.
    add_entry(STIM_RECV_HOLD, slm_pkg::OP_PUSH_FIRST, '0, 300, 0);
    add_list_pair(LIST_DEPTH + 2, 20, SHAPE_ASCEND);
    add_list_pair(10, 10, SHAPE_TIES);
    add_entry(STIM_DRAIN, slm_pkg::OP_PUSH_FIRST, '0, 0, 0);

    // Random phases with different idle and stall mixes.
    target = stim_items;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: add_entry(STIM_IDLE_MIX, slm_pkg::OP_PUSH_FIRST, '0, 0, 0);
        1: add_entry(STIM_IDLE_MIX, slm_pkg::OP_PUSH_FIRST, '0, 56, 0);
        2: add_entry(STIM_IDLE_MIX, slm_pkg::OP_PUSH_FIRST, '0, 0, 56);
        default: add_entry(STIM_IDLE_MIX, slm_pkg::OP_PUSH_FIRST, '0, 19, 19);
      endcase
      target += 90;
      while (stim_items < target)
        add_random_group();
      add_entry(STIM_DRAIN, slm_pkg::OP_PUSH_FIRST, '0, 0, 0);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!stim_done || merge_expected.size() != 0)
      @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);

    if (merge_expected.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", merge_expected.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
